>>> design/sbp_pkg.sv
// ----------------------------------------------------------------------------
// Simple-8b block packer package
// Transaction types, controller/datapath command and status groups, and the
// selector tables shared by the modules of the packer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbp_pkg;

    // Operation codes of an input transaction.
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Widths of the fixed fields.
    localparam int unsigned VALUE_BITS   = 64;
    localparam int unsigned PAYLOAD_BITS = 60;
    localparam int unsigned SEL_COUNT    = 16;

    // Selectors 0 and 1 are the run selectors.
    localparam logic [3:0] SEL_LONG_RUN  = 4'd0;
    localparam logic [3:0] SEL_SHORT_RUN = 4'd1;

    // Bit offset of the first packed value above the selector.
    localparam logic [5:0] FIRST_OFFSET = 6'd4;

    typedef struct packed {
        logic        operation;
        logic [63:0] value;
    } t_in;

    typedef struct packed {
        logic [63:0] packed_word;
        logic        last_block;
        logic        range_error;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_eval;
        logic pick;
        logic pack_eval;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;
        logic fill;
        logic empty;
        logic scan_done;
        logic is_run;
        logic pack_done;
        logic out_free;
    } t_sts;

    // Number of values that a selector packs.
    function automatic logic [7:0] sel_count(input logic [3:0] sel);
        logic [7:0] n;
        unique case (sel)
            4'd0:    n = 8'd240;
            4'd1:    n = 8'd120;
            4'd2:    n = 8'd60;
            4'd3:    n = 8'd30;
            4'd4:    n = 8'd20;
            4'd5:    n = 8'd15;
            4'd6:    n = 8'd12;
            4'd7:    n = 8'd10;
            4'd8:    n = 8'd8;
            4'd9:    n = 8'd7;
            4'd10:   n = 8'd6;
            4'd11:   n = 8'd5;
            4'd12:   n = 8'd4;
            4'd13:   n = 8'd3;
            4'd14:   n = 8'd2;
            default: n = 8'd1;
        endcase
        return n;
    endfunction

    // Bit width of one value under a selector; zero for the run selectors.
    function automatic logic [5:0] sel_width(input logic [3:0] sel);
        logic [5:0] w;
        unique case (sel)
            4'd0:    w = 6'd0;
            4'd1:    w = 6'd0;
            4'd2:    w = 6'd1;
            4'd3:    w = 6'd2;
            4'd4:    w = 6'd3;
            4'd5:    w = 6'd4;
            4'd6:    w = 6'd5;
            4'd7:    w = 6'd6;
            4'd8:    w = 6'd7;
            4'd9:    w = 6'd8;
            4'd10:   w = 6'd10;
            4'd11:   w = 6'd12;
            4'd12:   w = 6'd15;
            4'd13:   w = 6'd20;
            4'd14:   w = 6'd30;
            default: w = 6'd60;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> design/simple8b_block_packer.sv
// ----------------------------------------------------------------------------
// Simple-8b block packer
// An in-range push that does not fill the window is only stored. A block takes a
// scan of up to 240 values (a read and an evaluate state each), a pick state, a
// read and a pack state per value packed for selectors 2..15, and the output load.
// The window RAM has a single read port; no transaction is accepted until the
// block is handed off. Reset empties the window and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module simple8b_block_packer
    import sbp_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 240
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    t_cmd cmd;
    t_sts sts;

    sbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_data.operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_ready     (o_ready)
    );

    sbp_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_data  (i_data),
        .i_ready (i_ready),
        .o_sts   (sts),
        .o_data  (o_data),
        .o_valid (o_valid)
    );

endmodule

`default_nettype wire

>>> design/sbp_ram.sv
// ----------------------------------------------------------------------------
// Simple-8b block packer RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_ram #(
    parameter int unsigned WIDTH = 60,
    parameter int unsigned DEPTH = 240
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> design/sbp_datapath.sv
// ----------------------------------------------------------------------------
// Simple-8b block packer datapath
// Holds the value window as a circular buffer, scans it for the first
// fitting selector, assembles the packed word and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_datapath
    import sbp_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 240
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire t_in  i_data,
    input  wire logic i_ready,
    output t_sts      o_sts,
    output t_out      o_data,
    output logic      o_valid
);

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [AW:0] DEPTH_X = (AW+1)'(WINDOW_DEPTH);
    localparam logic [8:0] LONG_RUN = 9'd240;

    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_k, n_k;
    logic [15:0]    r_ok, n_ok;
    logic [15:0]    r_fit, n_fit;
    logic           r_first, n_first;
    logic           r_drain, n_drain;
    logic [3:0]     r_sel, n_sel;
    logic [5:0]     r_off, n_off;
    logic [63:0]    r_word, n_word;
    logic           r_err, n_err;
    logic           r_last, n_last;
    t_out           r_out;
    logic           r_out_valid;

    logic [AW:0]    rd_sum, wr_sum, drop_sum;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic           wr_en;
    logic [59:0]    rd_data;
    logic [8:0]     kp1, cnt9, lim9;
    logic [15:0]    ok_new, alive, dec;
    logic           first_bit, run_v;
    logic [3:0]     pick_sel;
    logic [7:0]     drop_n;
    logic           do_drop;
    logic [CW-1:0]  drop_count;

    // Circular addressing: read at head plus scan index, write at the tail.
    always_comb begin
        rd_sum  = {1'b0, r_head} + (AW+1)'(r_k);
        rd_addr = (rd_sum >= DEPTH_X) ? AW'(rd_sum - DEPTH_X) : AW'(rd_sum);
        wr_sum  = {1'b0, r_head} + (AW+1)'(r_count);
        wr_addr = (wr_sum >= DEPTH_X) ? AW'(wr_sum - DEPTH_X) : AW'(wr_sum);
        wr_en   = i_cmd.accept && (i_data.operation == OP_PUSH) && !o_sts.bad;
    end

    sbp_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data.value[59:0]),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Scan step: update the prefix fit flags with the value just read.
    always_comb begin
        kp1       = 9'(r_k) + 9'd1;
        cnt9      = 9'(r_count);
        lim9      = (cnt9 < LONG_RUN) ? cnt9 : LONG_RUN;
        first_bit = (r_k == '0) ? rd_data[0] : r_first;
        run_v     = r_ok[0] && (rd_data[59:1] == '0) && (rd_data[0] == first_bit);
        for (int s = 0; s < 16; s++) begin
            if (s < 2) begin
                ok_new[s] = run_v;
            end else begin
                ok_new[s] = r_ok[s] && ((rd_data >> sel_width(4'(s))) == '0);
            end
            dec[s]   = ({1'b0, sel_count(4'(s))} == kp1);
            alive[s] = ({1'b0, sel_count(4'(s))} > kp1)
                    && ({1'b0, sel_count(4'(s))} <= cnt9) && ok_new[s];
        end
    end

    // Lowest fitting selector.
    always_comb begin
        pick_sel = 4'd15;
        for (int s = 15; s >= 0; s--) begin
            if (r_fit[s]) begin
                pick_sel = 4'(s);
            end
        end
    end

    // Removal of the packed values from the window front.
    always_comb begin
        drop_n     = i_cmd.pick ? sel_count(pick_sel) : sel_count(r_sel);
        do_drop    = (i_cmd.pick && (pick_sel < 4'd2))
                  || (i_cmd.pack_eval && o_sts.pack_done);
        drop_sum   = {1'b0, r_head} + (AW+1)'(drop_n);
        drop_count = r_count - CW'(drop_n);
    end

    // Status toward the controller.
    always_comb begin
        o_sts.bad       = (i_data.value[63:60] != '0);
        o_sts.fill      = (9'(r_count) + 9'd1) == 9'(WINDOW_DEPTH);
        o_sts.empty     = (r_count == '0);
        o_sts.scan_done = !(|alive) || (kp1 == lim9);
        o_sts.is_run    = (pick_sel < 4'd2);
        o_sts.pack_done = (kp1 == {1'b0, sel_count(r_sel)});
        o_sts.out_free  = !r_out_valid || i_ready;
    end

    // Next-state logic of the working registers.
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_k     = r_k;
        n_ok    = r_ok;
        n_fit   = r_fit;
        n_first = r_first;
        n_drain = r_drain;
        n_sel   = r_sel;
        n_off   = r_off;
        n_word  = r_word;
        n_err   = r_err;
        n_last  = r_last;

        if (i_cmd.accept) begin
            n_drain = i_data.operation;
            n_k     = '0;
            n_ok    = '1;
            n_fit   = '0;
            n_err   = 1'b0;
            n_last  = 1'b0;
            if (i_data.operation == OP_PUSH) begin
                if (o_sts.bad) begin
                    n_word = '0;
                    n_err  = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
        end

        if (i_cmd.scan_eval) begin
            n_ok    = ok_new;
            n_fit   = r_fit | (dec & ok_new);
            n_first = first_bit;
            n_k     = r_k + CW'(1);
        end

        if (i_cmd.pick) begin
            n_sel = pick_sel;
            n_k   = '0;
            n_off = FIRST_OFFSET;
            if (pick_sel < 4'd2) begin
                n_word = {59'd0, r_first, pick_sel};
            end else begin
                n_word = 64'(pick_sel);
            end
        end

        if (i_cmd.pack_eval) begin
            n_word = r_word | ({4'd0, rd_data} << r_off);
            n_off  = r_off + sel_width(r_sel);
            n_k    = r_k + CW'(1);
        end

        if (do_drop) begin
            n_head  = (drop_sum >= DEPTH_X) ? AW'(drop_sum - DEPTH_X) : AW'(drop_sum);
            n_count = drop_count;
            n_last  = r_drain && (drop_count == '0);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_ok    <= n_ok;
        r_fit   <= n_fit;
        r_first <= n_first;
        r_drain <= n_drain;
        r_sel   <= n_sel;
        r_off   <= n_off;
        r_word  <= n_word;
        r_err   <= n_err;
        r_last  <= n_last;
        if (i_cmd.out_load) begin
            r_out.packed_word <= r_word;
            r_out.last_block  <= r_last;
            r_out.range_error <= r_err;
        end
    end

    assign o_data  = r_out;
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

>>> design/sbp_ctrl.sv
// ----------------------------------------------------------------------------
// Simple-8b block packer controller
// Sequences accept, window scan, selector pick, word assembly and result
// hand-off through commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_ctrl
    import sbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_operation,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_ready
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SCAN_RD = 7'b0000010,
        ST_SCAN_EV = 7'b0000100,
        ST_PICK    = 7'b0001000,
        ST_PACK_RD = 7'b0010000,
        ST_PACK_EV = 7'b0100000,
        ST_EMIT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // Commands issued in each state.
    always_comb begin
        o_cmd.accept    = accept;
        o_cmd.scan_eval = (r_state == ST_SCAN_EV);
        o_cmd.pick      = (r_state == ST_PICK);
        o_cmd.pack_eval = (r_state == ST_PACK_EV);
        o_cmd.out_load  = (r_state == ST_EMIT) && i_sts.out_free;
    end

    // State transitions.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_PUSH) begin
                        if (i_sts.bad) begin
                            n_state = ST_EMIT;
                        end else if (i_sts.fill) begin
                            n_state = ST_SCAN_RD;
                        end
                    end else if (!i_sts.empty) begin
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: n_state = ST_SCAN_EV;
            ST_SCAN_EV: n_state = i_sts.scan_done ? ST_PICK : ST_SCAN_RD;
            ST_PICK:    n_state = i_sts.is_run ? ST_EMIT : ST_PACK_RD;
            ST_PACK_RD: n_state = ST_PACK_EV;
            ST_PACK_EV: n_state = i_sts.pack_done ? ST_EMIT : ST_PACK_RD;
            ST_EMIT:    n_state = i_sts.out_free ? ST_IDLE : ST_EMIT;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
